/* design/rlws_pkg.sv */
// rlws_pkg: types and constants shared by the ripple wave sampler.
// No dependencies.
`timescale 1ns / 1ps
package rlws_pkg;

   localparam int DIV_N = 30;   // dividend width of the shared divider
   localparam int DIV_D = 22;   // divisor width of the shared divider

   localparam logic [2:0] REG_DURATION     = 3'd0;
   localparam logic [2:0] REG_MAX_RADIUS   = 3'd1;
   localparam logic [2:0] REG_RING_WIDTH   = 3'd2;
   localparam logic [2:0] REG_TRAIL_OFFSET = 3'd3;
   localparam logic [2:0] REG_TRAIL_WIDTH  = 3'd4;
   localparam logic [2:0] REG_TRAIL_LEVEL  = 3'd5;
   localparam logic [2:0] REG_HUE_SHIFT    = 3'd6;

   localparam logic [7:0] FULL_LEVEL = 8'd255;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] start;
      logic [7:0]  hue;
   } wave_type;

   typedef struct packed {
      logic [15:0] duration_ms;
      logic [9:0]  max_radius;
      logic [7:0]  ring_width;
      logic [7:0]  trail_offset;
      logic [7:0]  trail_width;
      logic [7:0]  trail_level;
      logic [15:0] hue_shift_ms;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_N-1:0] dividend;
      logic [DIV_D-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_N-1:0] quotient;
   } div_rsp_type;

endpackage

/* design/rlws_if.sv */
// rlws_if: request and response channel interfaces of the wave sampler.
// Stand alone; no package needed.
`timescale 1ns / 1ps
interface rlws_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [7:0]  x_pos;
   logic [7:0]  y_pos;
   logic [15:0] now_ms;
   logic [7:0]  wave_hue;
   modport source (output valid, cmd, x_pos, y_pos, now_ms, wave_hue, input ready);
   modport sink (input valid, cmd, x_pos, y_pos, now_ms, wave_hue, output ready);
endinterface

interface rlws_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] intensity;
   logic [7:0] out_hue;
   modport source (output valid, intensity, out_hue, input ready);
   modport sink (input valid, intensity, out_hue, output ready);
endinterface

/* design/rlws_wave_mem.sv */
// rlws_wave_mem: wave slot store, one write port, one registered read port.
// Uses rlws_pkg for the slot entry type.
`timescale 1ns / 1ps
module rlws_wave_mem
   import rlws_pkg::*;
#(
   parameter int DEPTH = 8,
   parameter int AW    = 3
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  wave_type      wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output wave_type      rd_data
);

   wave_type mem [DEPTH];
   wave_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/rlws_div.sv */
// rlws_div: restoring divider, one quotient bit per cycle.
// Uses rlws_pkg for widths and request/response structs.
`timescale 1ns / 1ps
module rlws_div
   import rlws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int CW = $clog2(DIV_N);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_N-1:0] quo_ff, quo_in;
   logic [DIV_D-1:0] rem_ff, rem_in;
   logic [DIV_D-1:0] dvs_ff, dvs_in;
   logic [DIV_D:0]   trial;
   logic [DIV_D:0]   diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[DIV_N-1]};
      diff    = trial - {1'b0, dvs_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DIV_N - 1);
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         if (!diff[DIV_D]) begin
            rem_in = diff[DIV_D-1:0];
            quo_in = {quo_ff[DIV_N-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_D-1:0];
            quo_in = {quo_ff[DIV_N-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.busy     = busy_ff;
   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

/* design/ripple_led_wave_sampler.sv */
// Ripple LED wave sampler: trigger items store waves, sample items shade one LED.
// Trigger: stores the wave, no item out. Sample: scans every slot, skipping idle slots,
// retiring expired waves and shading each live wave with up to four passes of the shared
// bit-serial divider (radius, ring, trail, hue). One item is worked at a time; a
// finished result waits in the output register. Synchronous reset clears valid bits,
// slot pointer and registers to defaults.
`timescale 1ns / 1ps
module ripple_led_wave_sampler
   import rlws_pkg::*;
#(
   parameter int MAX_WAVES = 8
) (
   input  logic              clock,
   input  logic              reset,
   rlws_req_if.sink          req_chan,
   rlws_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int SW = (MAX_WAVES > 1) ? $clog2(MAX_WAVES) : 1;
   localparam int CW = $clog2(MAX_WAVES + 1);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_RD     = 4'd2;
   localparam logic [3:0] S_AGE    = 4'd3;
   localparam logic [3:0] S_RDIV   = 4'd4;
   localparam logic [3:0] S_SH1    = 4'd5;
   localparam logic [3:0] S_SH2    = 4'd6;
   localparam logic [3:0] S_SH3    = 4'd7;
   localparam logic [3:0] S_SHDIV  = 4'd8;
   localparam logic [3:0] S_SHDONE = 4'd9;
   localparam logic [3:0] S_TLDIV  = 4'd10;
   localparam logic [3:0] S_ACC    = 4'd11;
   localparam logic [3:0] S_HDIV   = 4'd12;
   localparam logic [3:0] S_OUT    = 4'd13;

   cfg_type cfg_ff, cfg_in;
   logic [3:0] state_ff, state_in;
   logic [MAX_WAVES-1:0] active_ff, active_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic [7:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic [15:0] now_ff, now_in;
   logic [15:0] elapsed_ff, elapsed_in;
   logic [7:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [15:0] dxx_ff, dxx_in, dyy_ff, dyy_in;
   logic [16:0] d2_ff, d2_in;
   logic [9:0]  r_ff, r_in;
   logic [9:0]  shr_ff, shr_in;
   logic [7:0]  shw_ff, shw_in;
   logic        phase_ff, phase_in;
   logic        rzero_ff, rzero_in;
   logic [9:0]  lo_ff, lo_in;
   logic [10:0] hi_ff, hi_in;
   logic [19:0] lo2_ff, lo2_in, r2_ff, r2_in;
   logic [21:0] hi2_ff, hi2_in;
   logic [7:0]  ring_ff, ring_in, trail_ff, trail_in;
   logic [8:0]  vsum;
   logic [7:0]  v_ff, v_in;
   logic [7:0]  total_ff, total_in, best_ff, best_in, bhue_ff, bhue_in;
   logic [9:0]  tr;
   logic [8:0]  tsum;
   logic [15:0] tprod;
   logic [15:0] tround;
   logic [21:0] diff;
   logic [29:0] num;
   logic [7:0]  shval;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_int_ff, rsp_int_in, rsp_hue_ff, rsp_hue_in;

   logic        req_fire, mem_rd;
   wave_type    wr_data, rd_data;
   div_req_type dreq;
   div_rsp_type drsp;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign wr_data  = '{x: req_chan.x_pos, y: req_chan.y_pos,
                       start: req_chan.now_ms, hue: req_chan.wave_hue};
   assign mem_rd   = (state_ff == S_SCAN) && (idx_ff != CW'(MAX_WAVES))
                     && active_ff[idx_ff[SW-1:0]];

   rlws_wave_mem #(.DEPTH(MAX_WAVES), .AW(SW)) u_mem (
      .clock   (clock),
      .wr_en   (req_fire && !req_chan.cmd),
      .wr_addr (slot_ff),
      .wr_data (wr_data),
      .rd_en   (mem_rd),
      .rd_addr (idx_ff[SW-1:0]),
      .rd_data (rd_data)
   );

   rlws_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (dreq),
      .rsp   (drsp)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_DURATION:     cfg_in.duration_ms  = csr_wdata;
            REG_MAX_RADIUS:   cfg_in.max_radius   = csr_wdata[9:0];
            REG_RING_WIDTH:   cfg_in.ring_width   = csr_wdata[7:0];
            REG_TRAIL_OFFSET: cfg_in.trail_offset = csr_wdata[7:0];
            REG_TRAIL_WIDTH:  cfg_in.trail_width  = csr_wdata[7:0];
            REG_TRAIL_LEVEL:  cfg_in.trail_level  = csr_wdata[7:0];
            REG_HUE_SHIFT:    cfg_in.hue_shift_ms = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      sx_in      = sx_ff;
      sy_in      = sy_ff;
      now_in     = now_ff;
      elapsed_in = elapsed_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      dxx_in     = dxx_ff;
      dyy_in     = dyy_ff;
      d2_in      = d2_ff;
      r_in       = r_ff;
      shr_in     = shr_ff;
      shw_in     = shw_ff;
      phase_in   = phase_ff;
      rzero_in   = rzero_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      lo2_in     = lo2_ff;
      r2_in      = r2_ff;
      hi2_in     = hi2_ff;
      ring_in    = ring_ff;
      trail_in   = trail_ff;
      v_in       = v_ff;
      total_in   = total_ff;
      best_in    = best_ff;
      bhue_in    = bhue_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_int_in   = rsp_int_ff;
      rsp_hue_in   = rsp_hue_ff;
      dreq       = '0;
      tr         = (r_ff > 10'(cfg_ff.trail_offset)) ?
                   r_ff - 10'(cfg_ff.trail_offset) : '0;
      vsum       = 9'(ring_ff) + 9'(trail_ff);
      tsum       = 9'(total_ff) + 9'(v_ff);
      // x/255 as (x + x/256 + 1)/256, exact for any x up to 255*255
      tprod      = 16'(v_ff) * 16'(cfg_ff.trail_level);
      tround     = tprod + 16'(tprod[15:8]) + 16'd1;
      diff       = '0;
      num        = '0;
      shval      = rzero_ff ? FULL_LEVEL - drsp.quotient[7:0] : drsp.quotient[7:0];

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_chan.cmd) begin
                  active_in[slot_ff] = 1'b1;
                  slot_in = (slot_ff == SW'(MAX_WAVES - 1)) ? '0 : slot_ff + 1'b1;
               end else begin
                  sx_in    = req_chan.x_pos;
                  sy_in    = req_chan.y_pos;
                  now_in   = req_chan.now_ms;
                  idx_in   = '0;
                  total_in = '0;
                  best_in  = '0;
                  bhue_in  = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == CW'(MAX_WAVES)) begin
               state_in = S_OUT;
            end else if (mem_rd) begin
               state_in = S_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_RD: begin
            elapsed_in = now_ff - rd_data.start;
            dx_in = (sx_ff > rd_data.x) ? sx_ff - rd_data.x : rd_data.x - sx_ff;
            dy_in = (sy_ff > rd_data.y) ? sy_ff - rd_data.y : rd_data.y - sy_ff;
            state_in = S_AGE;
         end
         S_AGE: begin
            if (elapsed_ff >= cfg_ff.duration_ms) begin
               active_in[idx_ff[SW-1:0]] = 1'b0;
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end else begin
               dxx_in = 16'(dx_ff) * 16'(dx_ff);
               dyy_in = 16'(dy_ff) * 16'(dy_ff);
               dreq.start    = 1'b1;
               dreq.dividend = DIV_N'(26'(cfg_ff.max_radius) * 26'(elapsed_ff));
               dreq.divisor  = DIV_D'(cfg_ff.duration_ms);
               state_in = S_RDIV;
            end
         end
         S_RDIV: begin
            if (drsp.done) begin
               r_in     = drsp.quotient[9:0];
               shr_in   = drsp.quotient[9:0];
               shw_in   = cfg_ff.ring_width;
               phase_in = 1'b0;
               d2_in    = 17'(dxx_ff) + 17'(dyy_ff);
               state_in = S_SH1;
            end
         end
         S_SH1: begin
            lo_in = (shr_ff > 10'(shw_ff)) ? shr_ff - 10'(shw_ff) : '0;
            hi_in = 11'(shr_ff) + 11'(shw_ff);
            state_in = S_SH2;
         end
         S_SH2: begin
            lo2_in = 20'(lo_ff) * 20'(lo_ff);
            r2_in  = 20'(shr_ff) * 20'(shr_ff);
            hi2_in = 22'(hi_ff) * 22'(hi_ff);
            state_in = S_SH3;
         end
         S_SH3: begin
            rzero_in = (shr_ff == '0);
            // outside the ring, or a zero-width ring at the centre
            if ((20'(d2_ff) < lo2_ff) || (22'(d2_ff) > hi2_ff)) begin
               v_in     = '0;
               state_in = S_SHDONE;
            end else if ((shr_ff == '0) && (hi2_ff == '0)) begin
               v_in     = FULL_LEVEL;
               state_in = S_SHDONE;
            end else begin
               if (shr_ff == '0) begin
                  diff        = 22'(d2_ff);
                  dreq.divisor = hi2_ff;
               end else if (20'(d2_ff) <= r2_ff) begin
                  diff        = 22'(d2_ff) - 22'(lo2_ff);
                  dreq.divisor = 22'(r2_ff) - 22'(lo2_ff);
               end else begin
                  diff        = hi2_ff - 22'(d2_ff);
                  dreq.divisor = hi2_ff - 22'(r2_ff);
               end
               num = {diff, 8'b0} - 30'(diff);
               dreq.start    = 1'b1;
               dreq.dividend = num;
               state_in = S_SHDIV;
            end
         end
         S_SHDIV: begin
            if (drsp.done) begin
               v_in     = shval;
               state_in = S_SHDONE;
            end
         end
         S_SHDONE: begin
            if (!phase_ff) begin
               ring_in  = v_ff;
               shr_in   = tr;
               shw_in   = cfg_ff.trail_width;
               phase_in = 1'b1;
               state_in = S_SH1;
            end else begin
               trail_in = tround[15:8];
               state_in = S_TLDIV;
            end
         end
         S_TLDIV: begin
            v_in     = vsum[8] ? FULL_LEVEL : vsum[7:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            total_in = tsum[8] ? FULL_LEVEL : tsum[7:0];
            if (v_ff > best_ff) begin
               best_in = v_ff;
               if (cfg_ff.hue_shift_ms == '0) begin
                  bhue_in = rd_data.hue;
                  idx_in  = idx_ff + 1'b1;
                  state_in = S_SCAN;
               end else begin
                  dreq.start    = 1'b1;
                  dreq.dividend = DIV_N'(elapsed_ff);
                  dreq.divisor  = DIV_D'(cfg_ff.hue_shift_ms);
                  state_in = S_HDIV;
               end
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_HDIV: begin
            if (drsp.done) begin
               bhue_in  = rd_data.hue + drsp.quotient[7:0];
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = total_ff;
               rsp_hue_in   = bhue_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{duration_ms: 16'd1000, max_radius: 10'd224, ring_width: 8'd16,
                     trail_offset: 8'd24, trail_width: 8'd24, trail_level: 8'd128,
                     hue_shift_ms: 16'd8};
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         active_ff    <= active_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dxx_ff     <= dxx_in;
      dyy_ff     <= dyy_in;
      d2_ff      <= d2_in;
      r_ff       <= r_in;
      shr_ff     <= shr_in;
      shw_ff     <= shw_in;
      phase_ff   <= phase_in;
      rzero_ff   <= rzero_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      lo2_ff     <= lo2_in;
      r2_ff      <= r2_in;
      hi2_ff     <= hi2_in;
      ring_ff    <= ring_in;
      trail_ff   <= trail_in;
      v_ff       <= v_in;
      total_ff   <= total_in;
      best_ff    <= best_in;
      bhue_ff    <= bhue_in;
      rsp_int_ff <= rsp_int_in;
      rsp_hue_ff <= rsp_hue_in;
   end

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.intensity = rsp_int_ff;
   assign rsp_chan.out_hue   = rsp_hue_ff;

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      dreq.start |-> !drsp.busy) else $error("divider started while busy");

   a_trig_active: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_chan.cmd) |=> active_ff[$past(slot_ff)])
      else $error("triggered slot not active");

   a_trail_scaled: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TLDIV) |-> (trail_ff <= v_ff))
      else $error("scaled trail above its shade");

endmodule
